>>> rtl/core/sctc_pkg.sv
package sctc_pkg;

  localparam int unsigned SlotIdxW = 10;
  localparam logic [31:0] InvalidTag = 32'hFFFF_FFFF;

  localparam logic [1:0] ActRead  = 2'd0;
  localparam logic [1:0] ActWrite = 2'd1;
  localparam logic [1:0] ActFlush = 2'd2;

  typedef enum logic [1:0] {
    OpLookup = 2'd0,
    OpSweep  = 2'd1,
    OpFlush  = 2'd2
  } op_e;

  typedef struct packed {
    logic                vld;
    op_e                 op;
    logic                wr;
    logic                done;
    logic                wb;
    logic [SlotIdxW-1:0] slot;
    logic [31:0]         sector;
    logic [31:0]         wb_tag;
  } tok_t;

endpackage

>>> rtl/core/sctc_cell.sv
module sctc_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sctc_pkg::tok_t   tok_i,
  output sctc_pkg::tok_t   tok_o
);

  logic [31:0]    tag_q, tag_d;
  logic           vld_q, vld_d;
  logic           dirty_q, dirty_d;
  logic           used_q, used_d;
  logic           tok_vld_q;
  sctc_pkg::tok_t tok_q, tok_d;
  logic [31:0]    tag_eff;
  logic           here;

  assign tag_eff = vld_q ? tag_q : sctc_pkg::InvalidTag;
  assign here    = (tok_i.slot == sctc_pkg::SlotIdxW'(IDX));

  always_comb begin
    tag_d   = tag_q;
    vld_d   = vld_q;
    dirty_d = dirty_q;
    used_d  = used_q;
    tok_d   = tok_i;
    if (tok_i.vld) begin
      unique case (tok_i.op)
        sctc_pkg::OpLookup: begin
          if (!tok_i.done && tag_eff == tok_i.sector) begin
            used_d = 1'b1;
            if (tok_i.wr) begin
              dirty_d = 1'b1;
            end
            tok_d.done = 1'b1;
            tok_d.slot = sctc_pkg::SlotIdxW'(IDX);
          end
        end
        sctc_pkg::OpSweep: begin
          if (!tok_i.done) begin
            if (used_q) begin
              used_d = 1'b0;
            end else begin
              tok_d.wb     = dirty_q && vld_q;
              tok_d.wb_tag = tag_q;
              tag_d        = tok_i.sector;
              vld_d        = 1'b1;
              used_d       = 1'b1;
              dirty_d      = tok_i.wr;
              tok_d.done   = 1'b1;
              tok_d.slot   = sctc_pkg::SlotIdxW'(IDX);
            end
          end
        end
        sctc_pkg::OpFlush: begin
          if (here && vld_q && dirty_q) begin
            dirty_d      = 1'b0;
            tok_d.wb     = 1'b1;
            tok_d.wb_tag = tag_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= 1'b0;
      dirty_q   <= 1'b0;
      used_q    <= 1'b0;
      tok_vld_q <= 1'b0;
    end else begin
      vld_q     <= vld_d;
      dirty_q   <= dirty_d;
      used_q    <= used_d;
      tok_vld_q <= tok_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q <= tag_d;
    tok_q <= tok_d;
  end

  always_comb begin
    tok_o     = tok_q;
    tok_o.vld = tok_vld_q;
  end

`ifndef ASSERT_OFF
  a_used_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q |-> vld_q) else $error("used slot without valid tag");
  a_dirty_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dirty_q |-> vld_q) else $error("dirty slot without valid tag");
`endif

endmodule

>>> rtl/core/sctc_ctrl.sv
module sctc_ctrl #(
  parameter int unsigned SLOT_COUNT = 128
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  logic [1:0]     action_i,
  input  logic [31:0]    sector_number_i,
  input  logic [6:0]     flush_slot_i,
  output sctc_pkg::tok_t tok_o,
  input  sctc_pkg::tok_t tok_i,
  output logic           result_valid_o,
  output logic           hit_o,
  output logic [6:0]     slot_index_o,
  output logic           write_back_o,
  output logic [31:0]    write_back_sector_o,
  output logic           fill_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StRun  = 1'b1;

  logic        state_q, state_d;
  logic        res_vld_q, res_vld_d;
  logic        hit_q, hit_d;
  logic [6:0]  slot_q, slot_d;
  logic        wb_q, wb_d;
  logic [31:0] wb_sec_q, wb_sec_d;
  logic        fill_q, fill_d;
  logic        accept;

  assign accept = start_i && (state_q == StIdle);

  always_comb begin
    state_d   = state_q;
    res_vld_d = 1'b0;
    hit_d     = hit_q;
    slot_d    = slot_q;
    wb_d      = wb_q;
    wb_sec_d  = wb_sec_q;
    fill_d    = fill_q;
    tok_o     = '0;
    if (accept) begin
      priority if (action_i == sctc_pkg::ActFlush) begin
        if (32'(flush_slot_i) >= SLOT_COUNT) begin
          res_vld_d = 1'b1;
          hit_d     = 1'b0;
          slot_d    = flush_slot_i;
          wb_d      = 1'b0;
          wb_sec_d  = '0;
          fill_d    = 1'b0;
        end else begin
          tok_o.vld  = 1'b1;
          tok_o.op   = sctc_pkg::OpFlush;
          tok_o.slot = sctc_pkg::SlotIdxW'(flush_slot_i);
          state_d    = StRun;
        end
      end else if ((action_i == sctc_pkg::ActRead || action_i == sctc_pkg::ActWrite) &&
                   sector_number_i != sctc_pkg::InvalidTag) begin
        tok_o.vld    = 1'b1;
        tok_o.op     = sctc_pkg::OpLookup;
        tok_o.wr     = (action_i == sctc_pkg::ActWrite);
        tok_o.sector = sector_number_i;
        state_d      = StRun;
      end else begin
        res_vld_d = 1'b1;
        hit_d     = 1'b0;
        slot_d    = '0;
        wb_d      = 1'b0;
        wb_sec_d  = '0;
        fill_d    = 1'b0;
      end
    end else if (state_q == StRun && tok_i.vld) begin
      unique case (tok_i.op)
        sctc_pkg::OpLookup: begin
          if (tok_i.done) begin
            res_vld_d = 1'b1;
            hit_d     = 1'b1;
            slot_d    = 7'(tok_i.slot);
            wb_d      = 1'b0;
            wb_sec_d  = '0;
            fill_d    = 1'b0;
            state_d   = StIdle;
          end else begin
            tok_o      = tok_i;
            tok_o.op   = sctc_pkg::OpSweep;
            tok_o.done = 1'b0;
            tok_o.wb   = 1'b0;
          end
        end
        sctc_pkg::OpSweep: begin
          if (tok_i.done) begin
            res_vld_d = 1'b1;
            hit_d     = 1'b0;
            slot_d    = 7'(tok_i.slot);
            wb_d      = tok_i.wb;
            wb_sec_d  = tok_i.wb ? tok_i.wb_tag : 32'd0;
            fill_d    = 1'b1;
            state_d   = StIdle;
          end else begin
            tok_o = tok_i;
          end
        end
        default: begin
          res_vld_d = 1'b1;
          hit_d     = 1'b0;
          slot_d    = 7'(tok_i.slot);
          wb_d      = tok_i.wb;
          wb_sec_d  = tok_i.wb ? tok_i.wb_tag : 32'd0;
          fill_d    = 1'b0;
          state_d   = StIdle;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q    <= hit_d;
    slot_q   <= slot_d;
    wb_q     <= wb_d;
    wb_sec_q <= wb_sec_d;
    fill_q   <= fill_d;
  end

  assign busy_o              = (state_q == StRun);
  assign result_valid_o      = res_vld_q;
  assign hit_o               = hit_q;
  assign slot_index_o        = slot_q;
  assign write_back_o        = wb_q;
  assign write_back_sector_o = wb_sec_q;
  assign fill_o              = fill_q;

`ifndef ASSERT_OFF
  a_return_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_i.vld |-> state_q == StRun) else $error("token returned while idle");
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q |-> state_q == StIdle) else $error("result while request in flight");
  a_hit_no_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q |-> !(hit_q && (fill_q || wb_q))) else $error("hit with fill or write-back");
  a_second_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_i.vld && tok_i.op == sctc_pkg::OpSweep && !tok_i.done |=>
    !(tok_i.vld && tok_i.op == sctc_pkg::OpSweep))
    else $error("sweep token relaunched out of order");
`endif

endmodule

>>> rtl/core/sector_cache_tag_controller_core.sv
// Tag controller for a fully associative write-back sector cache.
// Request channel: action_i, sector_number_i, flush_slot_i are taken at a
// rising edge with start_i high and busy_o low. Result channel: one result
// per request, shown for exactly one cycle with result_valid_o high; the
// receiver cannot stall it and must take it in that cycle.
// The slots sit in a chain of SLOT_COUNT cells; a request token moves one
// cell per cycle and each cell compares, marks, claims or flushes its own slot.
// Path of a request from accept to the result strobe:
//   invalid sector, unknown action, flush slot out of range: no token sent
//   hit or flush: one pass of the token through the chain
//   miss: lookup then sweep pass; one more sweep if all slots were used
// busy_o stays high until the result is registered; one request is in the
// chain at a time, so no new request is taken before the last one's result.
// Reset empties every slot (all tags invalid, dirty and used clear) at once;
// no sweep is needed and a request can be accepted right after reset.
module sector_cache_tag_controller_core #(
  parameter int unsigned SLOT_COUNT = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  action_i,
  input  logic [31:0] sector_number_i,
  input  logic [6:0]  flush_slot_i,
  output logic        result_valid_o,
  output logic        hit_o,
  output logic [6:0]  slot_index_o,
  output logic        write_back_o,
  output logic [31:0] write_back_sector_o,
  output logic        fill_o
);

  sctc_pkg::tok_t chain [SLOT_COUNT+1];

  sctc_ctrl #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_ctrl (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .action_i           (action_i),
    .sector_number_i    (sector_number_i),
    .flush_slot_i       (flush_slot_i),
    .tok_o              (chain[0]),
    .tok_i              (chain[SLOT_COUNT]),
    .result_valid_o     (result_valid_o),
    .hit_o              (hit_o),
    .slot_index_o       (slot_index_o),
    .write_back_o       (write_back_o),
    .write_back_sector_o(write_back_sector_o),
    .fill_o             (fill_o)
  );

  for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
    sctc_cell #(
      .IDX(g)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .tok_i (chain[g]),
      .tok_o (chain[g+1])
    );
  end

endmodule
